### rtl/core/sscow_pkg.sv
// Package: types, widths and codes for the spline shape cell weight block.
package sscow_pkg;

  localparam int PosWidth  = 32;
  localparam int FracBits  = 16;
  localparam int Guard     = 6;
  localparam int WBits     = FracBits + Guard;   // 22
  localparam int PBits     = WBits + 1;          // p < 2.0
  localparam int DivSteps  = WBits + 1;          // quotient bits
  localparam int StepsPerStage = 4;
  localparam int DivStages = (DivSteps + StepsPerStage - 1) / StepsPerStage;
  localparam int WtWidth   = FracBits + 1;

  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrInverted = 3'd1;
  localparam logic [2:0] ErrWide     = 3'd2;
  localparam logic [2:0] ErrZero     = 3'd3;
  localparam logic [2:0] ErrOrder    = 3'd4;

  localparam logic [1:0] OrdFlat  = 2'd0;
  localparam logic [1:0] OrdTri   = 2'd1;
  localparam logic [1:0] OrdQuad  = 2'd2;
  localparam logic [1:0] OrdBad   = 2'd3;

  typedef struct packed {
    logic signed [PosWidth-1:0] position;
    logic [PosWidth-2:0]        half_width;
    logic signed [PosWidth-1:0] left_edge;
    logic signed [PosWidth-1:0] right_edge;
  } in_item_t;

  typedef struct packed {
    logic [WtWidth-1:0] weight;
    logic [2:0]         error_code;
  } out_item_t;

endpackage

### rtl/core/spline_shape_cell_overlap_weight.sv
// Spline shape cell weight: classify, divide over stages, evaluate, round.
// Throughput: one item per cycle; every stage is a register with a valid bit,
// and the whole pipe advances while the output register is empty or taken.
// Reset: rst_ni clears all valid bits and sets order_q to 1 (triangle).
// The restoring divider runs four quotient bits in each of its stages, three in the last.
module spline_shape_cell_overlap_weight (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sscow_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sscow_pkg::out_item_t out_data_o
);

  localparam int PW = sscow_pkg::PosWidth;
  localparam int W  = sscow_pkg::WBits;
  localparam int PB = sscow_pkg::PBits;
  localparam int NS = sscow_pkg::DivStages;
  localparam int SP = sscow_pkg::StepsPerStage;
  localparam int EW = PW + 2;                 // wide signed edge arithmetic
  localparam int QW = NS * SP;                // quotient register width
  localparam int MW = 2 * PB;                 // product width
  localparam logic [PB-1:0] OneW  = PB'(1) << W;
  localparam logic [PB-1:0] HalfW = PB'(1) << (W - 1);
  localparam logic [PB-1:0] TwoW  = PB'(1) << (W + 1);

  typedef struct packed {
    logic              vld;
    logic [2:0]        err;
    logic              zero;    // weight 0 (error or out of reach)
    logic              full;    // weight 1
    logic [1:0]        ord;
  } ctl_t;

  logic       adv;
  logic [1:0] order_q;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Hold the order register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= sscow_pkg::OrdTri;
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  // Stage 0: register input.
  ctl_t                s0_c_q;
  sscow_pkg::in_item_t s0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_c_q <= '0;
    else if (adv) s0_c_q <= {in_valid_i, sscow_pkg::ErrNone, 1'b0, 1'b0, order_q};
  end
  always_ff @(posedge clk_i) begin
    if (adv) s0_q <= in_data_i;
  end

  // Stage 1: classify, pick edge numerator u.
  logic signed [EW-1:0] x_w, h_w, l_w, r_w;
  ctl_t            c1_d, c1_q;
  logic [PW-1:0]   u_d, u_q, h_q;
  always_comb begin
    x_w = EW'(s0_q.position);
    h_w = $signed({3'b000, s0_q.half_width});
    l_w = EW'(s0_q.left_edge);
    r_w = EW'(s0_q.right_edge);
    c1_d = s0_c_q;
    u_d = '0;
    if (r_w < l_w) begin
      c1_d.err = sscow_pkg::ErrInverted; c1_d.zero = 1'b1;
    end else if (h_w > r_w - l_w) begin
      c1_d.err = sscow_pkg::ErrWide; c1_d.zero = 1'b1;
    end else if (h_w == '0) begin
      c1_d.err = sscow_pkg::ErrZero; c1_d.zero = 1'b1;
    end else if (s0_c_q.ord == sscow_pkg::OrdBad) begin
      c1_d.err = sscow_pkg::ErrOrder; c1_d.zero = 1'b1;
    end else if (x_w < l_w - h_w || x_w > r_w + h_w) begin
      c1_d.zero = 1'b1;
    end else if (x_w - l_w < h_w) begin
      u_d = PW'(x_w + h_w - l_w);
    end else if (r_w - x_w < h_w) begin
      u_d = PW'(r_w - x_w + h_w);
    end else begin
      c1_d.full = 1'b1;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c1_q <= '0;
    else if (adv) c1_q <= c1_d;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_q <= u_d;
      h_q <= {1'b0, s0_q.half_width};
    end
  end

  // Divider stages: restoring division, up to SP quotient bits per stage.
  ctl_t          dc_q [NS];
  logic [PW:0]   dr_q [NS];
  logic [QW-1:0] dq_q [NS];
  logic [PW-1:0] dh_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_div
    ctl_t          ci;
    logic [PW:0]   ri, rn;
    logic [QW-1:0] qi, qn;
    logic [PW-1:0] hi;
    if (s == 0) begin : g_first
      assign ci = c1_q;
      assign ri = {1'b0, u_q};
      assign qi = '0;
      assign hi = h_q;
    end else begin : g_next
      assign ci = dc_q[s-1];
      assign ri = dr_q[s-1];
      assign qi = dq_q[s-1];
      assign hi = dh_q[s-1];
    end
    always_comb begin
      rn = ri;
      qn = qi;
      for (int k = 0; k < SP; k++) begin
        if (s * SP + k < sscow_pkg::DivSteps) begin
          if (s * SP + k != 0) rn = {rn[PW-1:0], 1'b0};
          qn = {qn[QW-2:0], 1'b0};
          if (rn >= {1'b0, hi}) begin
            rn = rn - {1'b0, hi};
            qn[0] = 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dc_q[s] <= '0;
      else if (adv) dc_q[s] <= ci;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dr_q[s] <= rn; dq_q[s] <= qn; dh_q[s] <= hi;
      end
    end
  end

  // Stage A: form the polynomial argument a.
  logic [PB-1:0] p_w, a_d, a_q, pa_q;
  ctl_t          ca_q;
  logic [MW-1:0] sqm_q;
  assign p_w = PB'(dq_q[NS-1]);
  always_comb begin
    if (dc_q[NS-1].ord == sscow_pkg::OrdTri)
      a_d = (p_w < OneW) ? p_w : TwoW - p_w;
    else if (p_w < HalfW) a_d = p_w;
    else if (p_w < OneW + HalfW)
      a_d = (p_w >= OneW) ? p_w - OneW : OneW - p_w;
    else a_d = TwoW - p_w;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ca_q <= '0;
    else if (adv) ca_q <= dc_q[NS-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q <= a_d; pa_q <= p_w;
    end
  end

  // Stage B: square.
  ctl_t          cb_q;
  logic [PB-1:0] ab_q, pb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cb_q <= '0;
    else if (adv) cb_q <= ca_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqm_q <= MW'(a_q) * MW'(a_q);
      ab_q <= a_q; pb_q <= pa_q;
    end
  end

  // Stage C: cube.
  logic [PB-1:0] sq_w;
  logic [MW-1:0] cum_q;
  logic [PB-1:0] sqc_q, pc_q;
  ctl_t          cc_q;
  assign sq_w = PB'(sqm_q >> W);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cc_q <= '0;
    else if (adv) cc_q <= cb_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cum_q <= MW'(sq_w) * MW'(ab_q);
      sqc_q <= sq_w; pc_q <= pb_q;
    end
  end

  // Stage D: 2*cube/3 by reciprocal multiply; stage E makes the one correction.
  localparam int RW = PB + 2;
  localparam logic [RW-1:0] Recip3 = RW'(((64'd1 << RW) + 64'd2) / 64'd3);
  logic [PB:0]     tc_w;
  logic [2*RW-1:0] dv_q;
  logic [PB:0]     tcd_q;
  logic [PB-1:0]   sqd_q, pd_q, ad_q;
  ctl_t            cd_q;
  assign tc_w = {PB'(cum_q >> W), 1'b0};
  logic [PB-1:0] ac_q;
  always_ff @(posedge clk_i) begin
    if (adv) ac_q <= ab_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cd_q <= '0;
    else if (adv) cd_q <= cc_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q <= (2*RW)'(tc_w) * (2*RW)'(Recip3);
      tcd_q <= tc_w; sqd_q <= sqc_q; pd_q <= pc_q; ad_q <= ac_q;
    end
  end

  // Stage E: correct quotient, combine, round, saturate.
  logic [PB:0]   q3_w, g_w, rnd_w;
  logic [PB+1:0] chk_w;
  logic [sscow_pkg::WtWidth-1:0] wt_w;
  always_comb begin
    q3_w = (PB+1)'(dv_q >> RW);
    chk_w = (PB+2)'(q3_w) * (PB+2)'(3);
    if (chk_w > (PB+2)'(tcd_q)) q3_w = q3_w - 1'b1;
    else if ((PB+2)'(tcd_q) - chk_w >= (PB+2)'(3)) q3_w = q3_w + 1'b1;
    g_w = '0;
    case (cd_q.ord)
      sscow_pkg::OrdFlat: g_w = (PB+1)'(pd_q >> 1);
      sscow_pkg::OrdTri: begin
        if (pd_q < OneW) g_w = (PB+1)'(sqd_q >> 1);
        else g_w = (PB+1)'(OneW) - (PB+1)'(sqd_q >> 1);
      end
      default: begin
        if (pd_q < HalfW) g_w = q3_w;
        else if (pd_q < OneW + HalfW) begin
          if (pd_q >= OneW) g_w = (PB+1)'(HalfW) + (PB+1)'(ad_q) - q3_w;
          else g_w = (PB+1)'(HalfW) - (PB+1)'(ad_q) + q3_w;
        end else g_w = (PB+1)'(OneW) - q3_w;
      end
    endcase
    if (cd_q.full) g_w = (PB+1)'(OneW);
    rnd_w = (g_w + (PB+1)'(1 << (sscow_pkg::Guard - 1))) >> sscow_pkg::Guard;
    if (cd_q.zero) wt_w = '0;
    else if (rnd_w > (PB+1)'(1 << sscow_pkg::FracBits))
      wt_w = sscow_pkg::WtWidth'(1 << sscow_pkg::FracBits);
    else wt_w = sscow_pkg::WtWidth'(rnd_w);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (adv) out_valid_o <= cd_q.vld;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_o.weight <= wt_w;
      out_data_o.error_code <= cd_q.err;
    end
  end

endmodule

### test/spline_shape_cell_overlap_weight_test.sv
// Testbench for the spline shape cell overlap weight block: directed table, random items, scoreboard.
module spline_shape_cell_overlap_weight_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = sscow_pkg::DivStages + 6;
  localparam int WatchLimit = 4000;
  localparam longint OneW = 64'd1 << sscow_pkg::WBits;
  localparam longint HalfW = 64'd1 << (sscow_pkg::WBits - 1);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = sscow_pkg::OrdTri;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sscow_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sscow_pkg::out_item_t out_data_o;

  spline_shape_cell_overlap_weight uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #1 clk_i = ~clk_i;

  logic [1:0] shape_order = sscow_pkg::OrdTri;
  sscow_pkg::out_item_t weight_queue[$];
  int mismatches = 0;
  int items_sent = 0;
  int weights_seen = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  int nonzero_seen = 0;

  typedef struct {
    sscow_pkg::in_item_t   item;
    bit                    known;
    sscow_pkg::out_item_t  result;
  } stim_row_t;

  // Divide u by h to WBits fraction bits.
  function automatic longint shape_ratio(longint u, longint h);
    longint q;
    longint r;
    q = (u >= h) ? 1 : 0;
    r = q ? u - h : u;
    for (int i = 0; i < sscow_pkg::WBits; i++) begin
      r = r <<< 1;
      q = q <<< 1;
      if (r >= h) begin
        r -= h;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic longint square_w(longint a);
    return (a * a) >>> sscow_pkg::WBits;
  endfunction

  function automatic longint cube_w(longint a);
    return (square_w(a) * a) >>> sscow_pkg::WBits;
  endfunction

  function automatic longint edge_share(logic [1:0] ord, longint p);
    longint s;
    if (ord == sscow_pkg::OrdFlat) return p >>> 1;
    if (ord == sscow_pkg::OrdTri) begin
      if (p < OneW) return square_w(p) >>> 1;
      return OneW - (square_w(2 * OneW - p) >>> 1);
    end
    if (p < HalfW) return (2 * cube_w(p)) / 3;
    if (p < OneW + HalfW) begin
      if (p >= OneW) begin
        s = p - OneW;
        return HalfW + s - (2 * cube_w(s)) / 3;
      end
      s = OneW - p;
      return HalfW - s + (2 * cube_w(s)) / 3;
    end
    return OneW - (2 * cube_w(2 * OneW - p)) / 3;
  endfunction

  // Predict the overlap weight and error code of one item.
  function automatic sscow_pkg::out_item_t predict_weight(sscow_pkg::in_item_t it,
                                                          logic [1:0] ord);
    sscow_pkg::out_item_t res;
    longint x, h, lo, hi, g, w;
    x = longint'(it.position);
    h = longint'({1'b0, it.half_width});
    lo = longint'(it.left_edge);
    hi = longint'(it.right_edge);
    res.weight = '0;
    res.error_code = sscow_pkg::ErrNone;
    if (hi < lo) res.error_code = sscow_pkg::ErrInverted;
    else if (h > hi - lo) res.error_code = sscow_pkg::ErrWide;
    else if (h == 0) res.error_code = sscow_pkg::ErrZero;
    else if (ord == sscow_pkg::OrdBad) res.error_code = sscow_pkg::ErrOrder;
    else if (!(x < lo - h || x > hi + h)) begin
      if (x - lo < h) g = edge_share(ord, shape_ratio(x + h - lo, h));
      else if (hi - x < h) g = edge_share(ord, shape_ratio(hi - x + h, h));
      else g = OneW;
      w = (g + (64'd1 << (sscow_pkg::Guard - 1))) >>> sscow_pkg::Guard;
      if (w > (64'd1 << sscow_pkg::FracBits)) w = 64'd1 << sscow_pkg::FracBits;
      res.weight = w[sscow_pkg::WtWidth-1:0];
    end
    return res;
  endfunction

  // Build a well-formed item near a cell with random content.
  function automatic sscow_pkg::in_item_t near_cell_item();
    sscow_pkg::in_item_t it;
    longint lo, wid, h, x;
    lo = longint'($signed($urandom_range(32'h00FF_FFFF, 0))) - 64'h0080_0000;
    wid = $urandom_range(5, 1) == 1 ? $urandom_range(200, 1) : $urandom_range(32'h0008_0000, 2);
    h = $urandom_range(wid > 1 ? wid : 1, 1);
    x = lo - 2 * h + longint'($urandom_range(wid + 4 * h, 0));
    it.position = x[31:0];
    it.half_width = h[30:0];
    it.left_edge = lo[31:0];
    it.right_edge = lo[31:0] + wid[31:0];
    return it;
  endfunction

  function automatic sscow_pkg::in_item_t random_item();
    sscow_pkg::in_item_t it;
    case ($urandom_range(9, 0))
      0: begin
        it.position = $urandom;
        it.half_width = 31'($urandom);
        it.left_edge = $urandom;
        it.right_edge = $urandom;
      end
      1: begin
        it = near_cell_item();
        it.half_width = '0;
      end
      2: begin
        it = near_cell_item();
        it.half_width = 31'(it.half_width + $urandom_range(32'h0010_0000, 1) + 31'd2000000);
      end
      default: it = near_cell_item();
    endcase
    return it;
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_item(sscow_pkg::in_item_t it);
    if (!calm && $urandom_range(3, 0) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk_i);
    end
    in_data_i <= it;
    in_valid_i <= 1'b1;
    weight_queue.insert(weight_queue.size(), predict_weight(it, shape_order));
    items_sent++;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (weight_queue.size() != 0 && !timed_out) @(negedge clk_i);
    repeat (Latency + 2) @(negedge clk_i);
  endtask

  task automatic write_order(logic [1:0] ord);
    drain_results();
    cfg_wdata_i <= ord;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shape_order = ord;
  endtask

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (60) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(4, 0) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(6, 1) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each taken result with the oldest expectation.
  always @(posedge clk_i) begin
    sscow_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      weights_seen++;
      if (weight_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        want = weight_queue.pop_front();
        if (out_data_o.weight != 0) nonzero_seen++;
        if (out_data_o.weight !== want.weight || out_data_o.error_code !== want.error_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: weight exp %0d got %0d, code exp %0d got %0d",
                     want.weight, out_data_o.weight, want.error_code, out_data_o.error_code);
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    logic [1:0] order_plan[5];
    sscow_pkg::in_item_t it;
    order_plan = '{sscow_pkg::OrdFlat, sscow_pkg::OrdQuad, sscow_pkg::OrdBad,
                   sscow_pkg::OrdTri, sscow_pkg::OrdQuad};
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows: errors and extremes carry typed-in results.
    table_rows.insert(table_rows.size(), '{'{32'sd0, 31'd65536, 32'sd65536, -32'sd65536}, 1,
                      '{'0, sscow_pkg::ErrInverted}});
    table_rows.insert(table_rows.size(), '{'{32'sd0, 31'h7FFF_FFFF, 32'sd0, 32'sd65536}, 1,
                      '{'0, sscow_pkg::ErrWide}});
    table_rows.insert(table_rows.size(), '{'{32'sd0, 31'd0, -32'sd65536, 32'sd65536}, 1,
                      '{'0, sscow_pkg::ErrZero}});
    table_rows.insert(table_rows.size(),
                      '{'{32'sh7FFF_FFFF, 31'd0, 32'sh8000_0000, 32'sh7FFF_FFFF}, 1,
                        '{'0, sscow_pkg::ErrZero}});
    table_rows.insert(table_rows.size(),
                      '{'{32'sh8000_0000, 31'h7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF}, 0,
                        '{'0, sscow_pkg::ErrNone}});
    table_rows.insert(table_rows.size(), '{'{32'sd0, 31'd65536, -32'sd655360, 32'sd655360}, 1,
                      '{17'd65536, sscow_pkg::ErrNone}});
    table_rows.insert(table_rows.size(),
                      '{'{32'sd9999999, 31'd65536, -32'sd655360, 32'sd655360}, 1,
                        '{'0, sscow_pkg::ErrNone}});
    table_rows.insert(table_rows.size(),
                      '{'{-32'sd720896, 31'd65536, -32'sd655360, 32'sd655360}, 1,
                        '{'0, sscow_pkg::ErrNone}});
    table_rows.insert(table_rows.size(),
                      '{'{-32'sd655360, 31'd65536, -32'sd655360, 32'sd655360}, 0, '{'0, 0}});
    table_rows.insert(table_rows.size(),
                      '{'{32'sd655360, 31'd65536, -32'sd655360, 32'sd655360}, 0, '{'0, 0}});
    table_rows.insert(table_rows.size(),
                      '{'{-32'sd600000, 31'd65536, -32'sd655360, 32'sd655360}, 0, '{'0, 0}});
    table_rows.insert(table_rows.size(),
                      '{'{32'sd620000, 31'd65536, -32'sd655360, 32'sd655360}, 0, '{'0, 0}});
    table_rows.insert(table_rows.size(), '{'{32'sd1, 31'd1, 32'sd0, 32'sd1}, 0, '{'0, 0}});
    table_rows.insert(table_rows.size(),
                      '{'{32'sh7FFF_FFFF, 31'd1, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF}, 0,
                        '{'0, 0}});

    // Walk the table once per order, the bad order included.
    foreach (order_plan[k]) begin
      if (k < 4) begin
        write_order(order_plan[k]);
        foreach (table_rows[i]) begin
          row = table_rows[i];
          send_item(row.item);
          if (row.known && shape_order != sscow_pkg::OrdBad) weight_queue[$] = row.result;
        end
      end
    end

    // Random phases across several orders, pressure in the middle.
    for (int ph = 0; ph < 7; ph++) begin
      write_order(ph == 6 ? sscow_pkg::OrdTri : 2'($urandom_range(3, 0)));
      if (ph == 0) write_order(sscow_pkg::OrdFlat);
      if (ph == 1) write_order(sscow_pkg::OrdQuad);
      if (ph == 6) calm = 1'b1;
      for (int n = 0; n < 100; n++) begin
        if (ph == 3 && n == 10) hold_off = 1'b1;
        if (ph == 4 && n == 50) begin
          in_valid_i <= 1'b0;
          while (weight_queue.size() != 0) @(negedge clk_i);
        end
        it = random_item();
        send_item(it);
      end
    end
    drain_results();

    $display("Ran %0d items over all four order settings, %0d results, %0d nonzero weights.",
             items_sent, weights_seen, nonzero_seen);
    if (mismatches == 0 && weight_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, weight_queue.size());
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/sscow_pkg.sv
rtl/core/spline_shape_cell_overlap_weight.sv
test/spline_shape_cell_overlap_weight_test.sv
